>>> rtl/core/scrs_pkg.sv
// Shared types and constants of the site count range sum block.
package scrs_pkg;

    localparam int unsigned DEFAULT_SITE_CAPACITY = 1048576;
    localparam int unsigned DEFAULT_COUNT_BITS    = 16;

    localparam int unsigned INDEX_W = 20;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned RANGE_W = 21;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned COVER_W = 21;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [INDEX_W-1:0]  site_index;
        logic [COUNT_W-1:0]  meth_count;
        logic [COUNT_W-1:0]  unmeth_count;
        logic [RANGE_W-1:0]  range_start;
        logic [RANGE_W-1:0]  range_stop;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SWEEP,
        B_DRAIN,
        B_FINISH
    } back_state_t;

endpackage

>>> rtl/core/scrs_front.sv
// Front end: accepts requests, drops loads past the table and clamps query ranges.
module scrs_front #(
    parameter int unsigned SITE_CAPACITY = scrs_pkg::DEFAULT_SITE_CAPACITY
) (
    input  logic                         push,
    output logic                         full,
    input  logic                         req_type,
    input  logic [scrs_pkg::INDEX_W-1:0] site_index,
    input  logic [scrs_pkg::COUNT_W-1:0] meth_count,
    input  logic [scrs_pkg::COUNT_W-1:0] unmeth_count,
    input  logic [scrs_pkg::RANGE_W-1:0] range_start,
    input  logic [scrs_pkg::RANGE_W-1:0] range_stop,
    input  logic                         queue_full,
    output logic                         queue_wr,
    output scrs_pkg::cmd_t               queue_cmd
);
    import scrs_pkg::*;

    logic               accept;
    logic               keep;
    logic [RANGE_W-1:0] start_clamped;
    logic [RANGE_W-1:0] stop_clamped;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    always_comb
    begin
        start_clamped = range_start;
        stop_clamped  = range_stop;
        if ({11'd0, range_start} > 32'(SITE_CAPACITY))
        begin
            start_clamped = RANGE_W'(SITE_CAPACITY);
        end
        if ({11'd0, range_stop} > 32'(SITE_CAPACITY))
        begin
            stop_clamped = RANGE_W'(SITE_CAPACITY);
        end
    end

    always_comb
    begin
        queue_cmd.site_index   = site_index;
        queue_cmd.meth_count   = meth_count;
        queue_cmd.unmeth_count = unmeth_count;
        queue_cmd.range_start  = start_clamped;
        queue_cmd.range_stop   = stop_clamped;
        if (req_type == REQ_LOAD)
        begin
            queue_cmd.kind = CMD_LOAD;
            keep = {12'd0, site_index} < 32'(SITE_CAPACITY);
        end
        else
        begin
            queue_cmd.kind = (stop_clamped > start_clamped) ? CMD_QUERY : CMD_EMPTY;
            keep = 1'b1;
        end
    end

    assign queue_wr = accept && keep;

endmodule

>>> rtl/core/scrs_cmd_queue.sv
// Short command queue between the front end and the back end.
module scrs_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  scrs_pkg::cmd_t wr_cmd,
    output logic           queue_full,
    input  logic           rd,
    output scrs_pkg::cmd_t rd_cmd,
    output logic           queue_empty
);
    import scrs_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign queue_full  = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign queue_empty = count_reg == '0;
    assign rd_cmd      = slots_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots_reg[wptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> rtl/core/scrs_back.sv
// Back end: site table, range sweep with accumulation and the result register.
module scrs_back #(
    parameter int unsigned SITE_CAPACITY = scrs_pkg::DEFAULT_SITE_CAPACITY,
    parameter int unsigned COUNT_BITS    = scrs_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         queue_empty,
    input  scrs_pkg::cmd_t               queue_cmd,
    output logic                         queue_rd,
    output logic                         empty,
    input  logic                         pop,
    output logic [scrs_pkg::SUM_W-1:0]   sum_meth,
    output logic [scrs_pkg::SUM_W-1:0]   sum_unmeth,
    output logic [scrs_pkg::COVER_W-1:0] covered_sites
);
    import scrs_pkg::*;

    localparam int unsigned ADDR_W  = $clog2(SITE_CAPACITY);
    localparam int unsigned ENTRY_W = 2 * COUNT_BITS;

    logic [ENTRY_W-1:0] table_mem [SITE_CAPACITY];

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [RANGE_W-1:0] cur_reg;
    logic [RANGE_W-1:0] stop_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               rd_valid_reg;
    logic [SUM_W-1:0]   acc_meth_reg;
    logic [SUM_W-1:0]   acc_unmeth_reg;
    logic [COVER_W-1:0] acc_cover_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_meth_reg;
    logic [SUM_W-1:0]   out_unmeth_reg;
    logic [COVER_W-1:0] out_cover_reg;

    logic               mem_we;
    logic               mem_re;
    logic               start_query;
    logic               last_read;
    logic               out_free;
    logic               out_load;

    assign last_read = (cur_reg + 1'b1) == stop_reg;
    assign out_free  = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    unique case (queue_cmd.kind)
                        CMD_QUERY: state_next = B_SWEEP;
                        CMD_EMPTY: state_next = B_FINISH;
                        default:   state_next = B_IDLE;
                    endcase
                end
            end
            B_SWEEP:  state_next = last_read ? B_DRAIN : B_SWEEP;
            B_DRAIN:  state_next = B_FINISH;
            B_FINISH: state_next = out_free ? B_IDLE : B_FINISH;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        queue_rd    = (state_reg == B_IDLE) && !queue_empty;
        mem_we      = queue_rd && (queue_cmd.kind == CMD_LOAD);
        start_query = queue_rd && (queue_cmd.kind != CMD_LOAD);
        mem_re      = state_reg == B_SWEEP;
        out_load    = (state_reg == B_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= mem_re;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[ADDR_W'(queue_cmd.site_index)] <=
                {COUNT_BITS'(queue_cmd.meth_count), COUNT_BITS'(queue_cmd.unmeth_count)};
        end
        if (mem_re)
        begin
            rdata_reg <= table_mem[ADDR_W'(cur_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            cur_reg        <= queue_cmd.range_start;
            stop_reg       <= queue_cmd.range_stop;
            acc_meth_reg   <= '0;
            acc_unmeth_reg <= '0;
            acc_cover_reg  <= '0;
        end
        else
        begin
            if (mem_re)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
            if (rd_valid_reg)
            begin
                acc_meth_reg   <= acc_meth_reg + SUM_W'(rdata_reg[ENTRY_W-1:COUNT_BITS]);
                acc_unmeth_reg <= acc_unmeth_reg + SUM_W'(rdata_reg[COUNT_BITS-1:0]);
                if (|rdata_reg)
                begin
                    acc_cover_reg <= acc_cover_reg + 1'b1;
                end
            end
        end
        if (out_load)
        begin
            out_meth_reg   <= acc_meth_reg;
            out_unmeth_reg <= acc_unmeth_reg;
            out_cover_reg  <= acc_cover_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign sum_meth      = out_meth_reg;
    assign sum_unmeth    = out_unmeth_reg;
    assign covered_sites = out_cover_reg;

`ifndef NO_ASSERTIONS
    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SWEEP) |-> (cur_reg < stop_reg))
        else $error("Sweep address has passed the end of the range.");

    a_read_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg) == B_SWEEP))
        else $error("Table data arrived without a sweep read.");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_FINISH) && out_free) |=> (out_valid_reg && (state_reg == B_IDLE)))
        else $error("Finished query did not reach the result register.");
`endif

endmodule

>>> rtl/core/site_count_range_sum_core.sv
// Top level of the site count range sum block.
// The block holds a table of per-site methylated and unmethylated counts.
// Requests enter through a queue-like port: a request is taken at a rising
// edge with push high and full low. A load request writes one table entry and
// gives no result; a query request gives one result with both count sums and
// the number of covered sites over the half-open range of site indices.
// Results leave through empty and pop: the oldest result is shown while empty
// is low and is taken at an edge with pop high.
// A load is written to the table as the back end takes it from the queue. A
// query sweeps its range through the single table port, which reads one site
// per cycle, and then moves its sums into the result register. Up to four
// requests wait in the command queue, so loads and queries can be pushed
// while a sweep is running.
// When the receiver stalls, one result waits in the output register; the back
// end then holds the next result and the command queue fills until full rises.
// Reset empties the queue and the result register; table contents are
// undefined until written, so every queried site must have been loaded first.
module site_count_range_sum_core #(
    parameter int unsigned SITE_CAPACITY = scrs_pkg::DEFAULT_SITE_CAPACITY,
    parameter int unsigned COUNT_BITS    = scrs_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         req_type,
    input  logic [scrs_pkg::INDEX_W-1:0] site_index,
    input  logic [scrs_pkg::COUNT_W-1:0] meth_count,
    input  logic [scrs_pkg::COUNT_W-1:0] unmeth_count,
    input  logic [scrs_pkg::RANGE_W-1:0] range_start,
    input  logic [scrs_pkg::RANGE_W-1:0] range_stop,
    output logic                         empty,
    input  logic                         pop,
    output logic [scrs_pkg::SUM_W-1:0]   sum_meth,
    output logic [scrs_pkg::SUM_W-1:0]   sum_unmeth,
    output logic [scrs_pkg::COVER_W-1:0] covered_sites
);
    import scrs_pkg::*;

    logic queue_full;
    logic queue_wr;
    cmd_t queue_wr_cmd;
    logic queue_rd;
    cmd_t queue_rd_cmd;
    logic queue_empty;

    scrs_front #(
        .SITE_CAPACITY(SITE_CAPACITY)
    ) u_front (
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .site_index  (site_index),
        .meth_count  (meth_count),
        .unmeth_count(unmeth_count),
        .range_start (range_start),
        .range_stop  (range_stop),
        .queue_full  (queue_full),
        .queue_wr    (queue_wr),
        .queue_cmd   (queue_wr_cmd)
    );

    scrs_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (queue_wr),
        .wr_cmd     (queue_wr_cmd),
        .queue_full (queue_full),
        .rd         (queue_rd),
        .rd_cmd     (queue_rd_cmd),
        .queue_empty(queue_empty)
    );

    scrs_back #(
        .SITE_CAPACITY(SITE_CAPACITY),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_cmd    (queue_rd_cmd),
        .queue_rd     (queue_rd),
        .empty        (empty),
        .pop          (pop),
        .sum_meth     (sum_meth),
        .sum_unmeth   (sum_unmeth),
        .covered_sites(covered_sites)
    );

endmodule
